FILE: sv/vsid_pkg.sv
package vsid_pkg;

    localparam int CoordWidth  = 12;
    localparam int GainWidth   = 16;
    localparam int LimitWidth  = 20;
    localparam int TimeWidth   = 20;
    localparam int DtWidth     = 17;
    localparam int ErrWidth    = 13;
    localparam int SpeedWidth  = 21;
    localparam int MulAWidth   = 30;
    localparam int MulBWidth   = 18;
    localparam int ProdWidth   = MulAWidth + MulBWidth;
    localparam int AddWidth    = 24;
    localparam int GainShift   = 24;
    localparam int CfgIdxWidth = 3;

    localparam logic [LimitWidth-1:0] LIMIT_CAP = 20'd524288;
    localparam logic [DtWidth-1:0]    DT_MIN_US = 17'd1000;
    localparam logic [DtWidth-1:0]    DT_MAX_US = 17'd100000;

    localparam logic [CoordWidth-1:0] CENTER_H_RESET = 12'd180;
    localparam logic [CoordWidth-1:0] CENTER_V_RESET = 12'd180;
    localparam logic [GainWidth-1:0]  GAIN_T_RESET   = 16'd6108;
    localparam logic [GainWidth-1:0]  GAIN_F_RESET   = 16'd6108;
    localparam logic [LimitWidth-1:0] LIMIT_RESET    = 20'd196608;

    localparam logic [CfgIdxWidth-1:0] REG_CENTER_H = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_CENTER_V = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_GAIN_T   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_GAIN_F   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_LIMIT    = 3'd4;

    typedef struct packed {
        logic signed [MulAWidth-1:0] mul_a;
        logic signed [MulBWidth-1:0] mul_b;
        logic signed [AddWidth-1:0]  add_a;
        logic signed [AddWidth-1:0]  add_b;
        logic                        sub;
        logic [LimitWidth-1:0]       lim;
    } alu_req_t;

    typedef struct packed {
        logic signed [ProdWidth-1:0]  prod;
        logic signed [SpeedWidth-1:0] sum;
    } alu_rsp_t;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_MUL_H   = 10'b00_0000_0010,
        ST_SCALE_H = 10'b00_0000_0100,
        ST_ACC_H   = 10'b00_0000_1000,
        ST_MUL_V   = 10'b00_0001_0000,
        ST_SCALE_V = 10'b00_0010_0000,
        ST_ACC_V   = 10'b00_0100_0000,
        ST_MIX_L   = 10'b00_1000_0000,
        ST_MIX_R   = 10'b01_0000_0000,
        ST_WRITE   = 10'b10_0000_0000
    } state_t;

endpackage

FILE: sv/visual_servo_integrator_drive_unit.sv
// Visual servo integral controller with differential drive mixing.
// Input stream: one request per control tick carrying the object position,
// the elapsed time and, on s_tuser, whether the object was seen.
// Output stream: one request per input with both wheel setpoints and both
// integrator values, signed Q4.16.
// Configuration: write cfg_data into register cfg_index while cfg_wr_en is
// high, only when no tick is in flight.
// A seen tick runs multiply, scale and accumulate on the turn axis, then on
// the forward axis, then the left and right mix and the write step; a lost
// tick goes straight to the write step. One 30x18 multiplier serves both axes
// and one add/clamp unit both axes and the mix; s_tready stays low until the write.
// The output register holds its request until m_tready; the next tick may be
// accepted meanwhile, but its result waits in the last step until the
// output register frees up.
// Reset clears both integrators, drops m_tvalid and restores the default
// configuration.
module visual_servo_integrator_drive_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // object_col[11:0], object_row[23:12], elapsed_us[43:24], zero fill
    input  logic [47:0]                         s_tdata,
    // object_seen
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_speed[20:0], right_speed[41:21], turn_integral[62:42],
    // forward_integral[83:63], zero fill
    output logic [87:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [vsid_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [vsid_pkg::LimitWidth-1:0]     cfg_data
);
    import vsid_pkg::*;

    logic [CoordWidth-1:0] center_h_reg, center_h_next;
    logic [CoordWidth-1:0] center_v_reg, center_v_next;
    logic [GainWidth-1:0]  gain_t_reg, gain_t_next;
    logic [GainWidth-1:0]  gain_f_reg, gain_f_next;
    logic [LimitWidth-1:0] limit_reg, limit_next;

    always_comb begin
        center_h_next = center_h_reg;
        center_v_next = center_v_reg;
        gain_t_next   = gain_t_reg;
        gain_f_next   = gain_f_reg;
        limit_next    = limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_H: center_h_next = cfg_data[CoordWidth-1:0];
                REG_CENTER_V: center_v_next = cfg_data[CoordWidth-1:0];
                REG_GAIN_T:   gain_t_next   = cfg_data[GainWidth-1:0];
                REG_GAIN_F:   gain_f_next   = cfg_data[GainWidth-1:0];
                REG_LIMIT:    limit_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_h_reg <= CENTER_H_RESET;
            center_v_reg <= CENTER_V_RESET;
            gain_t_reg   <= GAIN_T_RESET;
            gain_f_reg   <= GAIN_F_RESET;
            limit_reg    <= LIMIT_RESET;
        end else begin
            center_h_reg <= center_h_next;
            center_v_reg <= center_v_next;
            gain_t_reg   <= gain_t_next;
            gain_f_reg   <= gain_f_next;
            limit_reg    <= limit_next;
        end
    end

    vsid_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .center_h  (center_h_reg),
        .center_v  (center_v_reg),
        .gain_t    (gain_t_reg),
        .gain_f    (gain_f_reg),
        .vel_limit (limit_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: sv/vsid_alu.sv
module vsid_alu (
    input  vsid_pkg::alu_req_t req,
    output vsid_pkg::alu_rsp_t rsp
);
    import vsid_pkg::*;

    logic signed [AddWidth:0]   sum_wide;
    logic signed [AddWidth:0]   lim_pos;
    logic signed [AddWidth:0]   lim_neg;
    logic signed [SpeedWidth-1:0] lim_s;

    always_comb begin
        rsp.prod = req.mul_a * req.mul_b;
        sum_wide = req.sub ? ({req.add_a[AddWidth-1], req.add_a}
                              - {req.add_b[AddWidth-1], req.add_b})
                           : ({req.add_a[AddWidth-1], req.add_a}
                              + {req.add_b[AddWidth-1], req.add_b});
        lim_pos  = $signed({{(AddWidth+1-LimitWidth){1'b0}}, req.lim});
        lim_neg  = -lim_pos;
        lim_s    = $signed({1'b0, req.lim});
        if (sum_wide > lim_pos) begin
            rsp.sum = lim_s;
        end else if (sum_wide < lim_neg) begin
            rsp.sum = -lim_s;
        end else begin
            rsp.sum = sum_wide[SpeedWidth-1:0];
        end
    end

endmodule

FILE: sv/vsid_core.sv
module vsid_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [vsid_pkg::CoordWidth-1:0]      center_h,
    input  logic [vsid_pkg::CoordWidth-1:0]      center_v,
    input  logic [vsid_pkg::GainWidth-1:0]       gain_t,
    input  logic [vsid_pkg::GainWidth-1:0]       gain_f,
    input  logic [vsid_pkg::LimitWidth-1:0]      vel_limit,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [87:0]                          m_tdata
);
    import vsid_pkg::*;

    state_t state_reg, state_next;

    logic signed [ErrWidth-1:0]   err_h_reg, err_h_next;
    logic signed [ErrWidth-1:0]   err_v_reg, err_v_next;
    logic [DtWidth-1:0]           dt_reg, dt_next;
    logic [LimitWidth-1:0]        lim_reg, lim_next;
    logic signed [ProdWidth-1:0]  prod_reg, prod_next;
    logic signed [SpeedWidth-1:0] turn_reg, turn_next;
    logic signed [SpeedWidth-1:0] fwd_reg, fwd_next;
    logic signed [SpeedWidth-1:0] left_reg, left_next;
    logic signed [SpeedWidth-1:0] right_reg, right_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [87:0]                  m_tdata_reg, m_tdata_next;

    logic [CoordWidth-1:0]        in_col;
    logic [CoordWidth-1:0]        in_row;
    logic [TimeWidth-1:0]         in_time;
    logic [DtWidth-1:0]           dt_clamped;
    logic                         accept;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    vsid_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign in_col   = s_tdata[11:0];
    assign in_row   = s_tdata[23:12];
    assign in_time  = s_tdata[43:24];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        priority if (in_time < TimeWidth'(DT_MIN_US)) begin
            dt_clamped = DT_MIN_US;
        end else if (in_time > TimeWidth'(DT_MAX_US)) begin
            dt_clamped = DT_MAX_US;
        end else begin
            dt_clamped = in_time[DtWidth-1:0];
        end
    end

    always_comb begin
        alu_req.mul_a = MulAWidth'(err_h_reg);
        alu_req.mul_b = $signed({2'b00, gain_t});
        alu_req.add_a = AddWidth'(turn_reg);
        alu_req.add_b = prod_reg[ProdWidth-1-:AddWidth];
        alu_req.sub   = 1'b0;
        alu_req.lim   = lim_reg;
        unique case (state_reg)
            ST_MUL_V: begin
                alu_req.mul_a = MulAWidth'(err_v_reg);
                alu_req.mul_b = $signed({2'b00, gain_f});
            end
            ST_SCALE_H, ST_SCALE_V: begin
                alu_req.mul_a = prod_reg[MulAWidth-1:0];
                alu_req.mul_b = $signed({1'b0, dt_reg});
            end
            ST_ACC_V: begin
                alu_req.add_a = AddWidth'(fwd_reg);
            end
            ST_MIX_L: begin
                alu_req.add_b = AddWidth'(fwd_reg);
                alu_req.sub   = 1'b1;
            end
            ST_MIX_R: begin
                alu_req.add_b = AddWidth'(fwd_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        err_h_next    = err_h_reg;
        err_v_next    = err_v_reg;
        dt_next       = dt_reg;
        lim_next      = lim_reg;
        prod_next     = prod_reg;
        turn_next     = turn_reg;
        fwd_next      = fwd_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    err_h_next = $signed({1'b0, center_h}) - $signed({1'b0, in_col});
                    err_v_next = $signed({1'b0, center_v}) - $signed({1'b0, in_row});
                    dt_next    = dt_clamped;
                    lim_next   = (vel_limit > LIMIT_CAP) ? LIMIT_CAP : vel_limit;
                    if (s_tuser) begin
                        state_next = ST_MUL_H;
                    end else begin
                        turn_next  = '0;
                        fwd_next   = '0;
                        left_next  = '0;
                        right_next = '0;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_MUL_H: begin
                prod_next  = alu_rsp.prod;
                state_next = ST_SCALE_H;
            end
            ST_SCALE_H: begin
                prod_next  = alu_rsp.prod;
                state_next = ST_ACC_H;
            end
            ST_ACC_H: begin
                turn_next  = alu_rsp.sum;
                state_next = ST_MUL_V;
            end
            ST_MUL_V: begin
                prod_next  = alu_rsp.prod;
                state_next = ST_SCALE_V;
            end
            ST_SCALE_V: begin
                prod_next  = alu_rsp.prod;
                state_next = ST_ACC_V;
            end
            ST_ACC_V: begin
                fwd_next   = alu_rsp.sum;
                state_next = ST_MIX_L;
            end
            ST_MIX_L: begin
                left_next  = alu_rsp.sum;
                state_next = ST_MIX_R;
            end
            ST_MIX_R: begin
                right_next = alu_rsp.sum;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, fwd_reg, turn_reg, right_reg, left_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            turn_reg     <= '0;
            fwd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            turn_reg     <= turn_next;
            fwd_reg      <= fwd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_h_reg   <= err_h_next;
        err_v_reg   <= err_v_next;
        dt_reg      <= dt_next;
        lim_reg     <= lim_next;
        prod_reg    <= prod_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

FILE: bench/visual_servo_integrator_drive_unit_test.sv
`timescale 1ns / 1ps

module visual_servo_integrator_drive_unit_test;
    import vsid_pkg::*;

    localparam int HoldCycles    = 400;
    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles  = 12;
    localparam int TailCycles    = 20;
    localparam int RandomPhases  = 7;
    localparam int PhaseTicks    = 200;
    localparam int PrintCap      = 100;

    localparam logic [CfgIdxWidth-1:0] RegSpareLo = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegSpareHi = 3'd7;

    typedef struct packed {
        logic signed [SpeedWidth-1:0] forward_integral;
        logic signed [SpeedWidth-1:0] turn_integral;
        logic signed [SpeedWidth-1:0] right_speed;
        logic signed [SpeedWidth-1:0] left_speed;
    } drive_t;

    typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CfgIdxWidth-1:0]   idx;
        logic [LimitWidth-1:0]    val;
        logic [CoordWidth-1:0]    col;
        logic [CoordWidth-1:0]    row;
        logic                     seen;
        logic [TimeWidth-1:0]     elapsed;
        bit                       zero_result;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [87:0]            m_tdata;
    logic                   cfg_wr_en;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [LimitWidth-1:0]  cfg_data;

    logic [CoordWidth-1:0] ctr_col;
    logic [CoordWidth-1:0] ctr_row;
    logic [GainWidth-1:0]  gain_h;
    logic [GainWidth-1:0]  gain_v;
    logic [LimitWidth-1:0] speed_cap;
    longint                turn_level;
    longint                forward_level;

    drive_t    pending_drive[$];
    stim_row_t directed_rows[$];
    drive_t    got_res;
    drive_t    want_res;

    bit hold_req;
    int idle_cycles;
    int mismatches;
    int tick_count;
    int lost_count;
    int write_count;
    int checked_count;

    visual_servo_integrator_drive_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic drive_t drive_step(logic [CoordWidth-1:0] col,
                                          logic [CoordWidth-1:0] row,
                                          logic seen,
                                          logic [TimeWidth-1:0] elapsed);
        longint lim;
        longint dt;
        longint err_h;
        longint err_v;
        drive_t r;
        lim = (speed_cap > LIMIT_CAP) ? longint'(LIMIT_CAP) : longint'(speed_cap);
        dt = longint'(elapsed);
        if (dt < longint'(DT_MIN_US)) dt = longint'(DT_MIN_US);
        if (dt > longint'(DT_MAX_US)) dt = longint'(DT_MAX_US);
        r = '0;
        if (seen) begin
            err_h = longint'(ctr_col) - longint'(col);
            err_v = longint'(ctr_row) - longint'(row);
            turn_level = clip(turn_level + ((err_h * longint'(gain_h) * dt) >>> GainShift),
                              lim);
            forward_level = clip(forward_level
                                 + ((err_v * longint'(gain_v) * dt) >>> GainShift), lim);
            r.left_speed  = SpeedWidth'(clip(turn_level - forward_level, lim));
            r.right_speed = SpeedWidth'(clip(forward_level + turn_level, lim));
        end else begin
            turn_level = 0;
            forward_level = 0;
        end
        r.turn_integral    = SpeedWidth'(turn_level);
        r.forward_integral = SpeedWidth'(forward_level);
        return r;
    endfunction

    function automatic logic [CoordWidth-1:0] near_center(logic [CoordWidth-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return CoordWidth'(v);
    endfunction

    function automatic logic [CoordWidth-1:0] pick_center();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CoordWidth'($urandom_range(0, 4095));
    endfunction

    function automatic logic [GainWidth-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return GainWidth'($urandom_range(0, 8191));
        return GainWidth'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic void add_tick(logic [CoordWidth-1:0] col, logic [CoordWidth-1:0] row,
                                     logic seen, logic [TimeWidth-1:0] elapsed,
                                     bit zero_result);
        stim_row_t r;
        r.kind = ROW_TICK;
        r.idx = '0;
        r.val = '0;
        r.col = col;
        r.row = row;
        r.seen = seen;
        r.elapsed = elapsed;
        r.zero_result = zero_result;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_write(logic [CfgIdxWidth-1:0] idx,
                                      logic [LimitWidth-1:0] val);
        stim_row_t r;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.val = val;
        r.col = '0;
        r.row = '0;
        r.seen = 1'b0;
        r.elapsed = '0;
        r.zero_result = 1'b0;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= PrintCap)
            $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic send_tick(logic [CoordWidth-1:0] col, logic [CoordWidth-1:0] row,
                             logic seen, logic [TimeWidth-1:0] elapsed,
                             int gap, bit zero_result);
        drive_t want;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {4'b0, elapsed, row, col};
        s_tuser = seen;
        do @(posedge aclk); while (!s_tready);
        want = drive_step(col, row, seen, elapsed);
        if (zero_result) want = '0;
        pending_drive.push_back(want);
        tick_count++;
        if (!seen) lost_count++;
    endtask

    task automatic write_register(logic [CfgIdxWidth-1:0] idx, logic [LimitWidth-1:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_CENTER_H: ctr_col = val[CoordWidth-1:0];
            REG_CENTER_V: ctr_row = val[CoordWidth-1:0];
            REG_GAIN_T:   gain_h = val[GainWidth-1:0];
            REG_GAIN_F:   gain_v = val[GainWidth-1:0];
            REG_LIMIT:    speed_cap = val;
            default: ;
        endcase
        write_count++;
    endtask

    task automatic drive_ready(logic level, int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            m_tready = level;
        end
    endtask

    initial begin
        int pick;
        m_tready = 1'b0;
        forever begin
            if (hold_req) begin
                drive_ready(1'b0, HoldCycles);
                hold_req = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    drive_ready(1'b1, $urandom_range(50, 150));
                end else begin
                    drive_ready(1'b1, $urandom_range(1, 6));
                    drive_ready(1'b0, (pick < 87) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready) begin
                got_res = drive_t'(m_tdata[4*SpeedWidth-1:0]);
                if (pending_drive.size() == 0) begin
                    report_mismatch("result with no request pending", 0, 0);
                end else begin
                    want_res = pending_drive.pop_front();
                    checked_count++;
                    if (got_res.left_speed !== want_res.left_speed)
                        report_mismatch("left_speed", got_res.left_speed,
                                        want_res.left_speed);
                    if (got_res.right_speed !== want_res.right_speed)
                        report_mismatch("right_speed", got_res.right_speed,
                                        want_res.right_speed);
                    if (got_res.turn_integral !== want_res.turn_integral)
                        report_mismatch("turn_integral", got_res.turn_integral,
                                        want_res.turn_integral);
                    if (got_res.forward_integral !== want_res.forward_integral)
                        report_mismatch("forward_integral", got_res.forward_integral,
                                        want_res.forward_integral);
                end
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t ns  no request moved for %0d cycles", $time, idle_cycles);
                $display("visual_servo_integrator_drive_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t r;
        logic [CoordWidth-1:0] col;
        logic [CoordWidth-1:0] row;
        logic [TimeWidth-1:0]  elapsed;
        logic [LimitWidth-1:0] lim;
        logic                  seen;
        int                    pick;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        idle_cycles = 0;
        mismatches = 0;
        tick_count = 0;
        lost_count = 0;
        write_count = 0;
        checked_count = 0;
        ctr_col = CENTER_H_RESET;
        ctr_row = CENTER_V_RESET;
        gain_h = GAIN_T_RESET;
        gain_v = GAIN_F_RESET;
        speed_cap = LIMIT_RESET;
        turn_level = 0;
        forward_level = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        add_tick(12'd0, 12'd0, 1'b0, 20'd0, 1'b1);
        add_tick(12'd180, 12'd180, 1'b1, 20'd50000, 1'b1);
        add_tick(12'd0, 12'd4095, 1'b1, 20'd0, 1'b0);
        add_tick(12'd4095, 12'd0, 1'b1, 20'hFFFFF, 1'b0);
        add_tick(12'd0, 12'd0, 1'b1, 20'd100000, 1'b0);
        add_tick(12'd4095, 12'd4095, 1'b1, 20'd1000, 1'b0);
        add_tick(12'd4095, 12'd4095, 1'b0, 20'hFFFFF, 1'b1);
        add_write(REG_GAIN_T, 20'd65535);
        add_write(REG_GAIN_F, 20'd65535);
        add_write(REG_LIMIT, 20'hFFFFF);
        add_write(REG_CENTER_H, 20'd0);
        add_write(REG_CENTER_V, 20'd4095);
        add_tick(12'd4095, 12'd0, 1'b1, 20'd100000, 1'b0);
        add_tick(12'd4095, 12'd0, 1'b1, 20'd100000, 1'b0);
        add_write(REG_LIMIT, 20'd1000);
        add_tick(12'd0, 12'd4095, 1'b1, 20'd1000, 1'b0);
        add_write(RegSpareHi, 20'hFFFFF);
        add_tick(12'd0, 12'd4095, 1'b1, 20'd1000, 1'b0);
        add_write(REG_LIMIT, 20'd0);
        add_tick(12'd4095, 12'd0, 1'b1, 20'd100000, 1'b1);
        add_tick(12'd4095, 12'd0, 1'b1, 20'd100000, 1'b1);
        add_write(REG_LIMIT, 20'd524288);
        add_write(REG_GAIN_T, 20'd1);
        add_write(REG_GAIN_F, 20'd1);
        add_write(REG_CENTER_H, 20'd180);
        add_write(REG_CENTER_V, 20'd180);
        add_tick(12'd181, 12'd179, 1'b1, 20'd1000, 1'b0);
        add_tick(12'd181, 12'd179, 1'b1, 20'd999, 1'b0);
        add_write(REG_GAIN_T, 20'd0);
        add_write(REG_GAIN_F, 20'd0);
        add_tick(12'd0, 12'd4095, 1'b1, 20'd100000, 1'b0);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_WRITE)
                write_register(r.idx, r.val);
            else
                send_tick(r.col, r.row, r.seen, r.elapsed, pick_gap(), r.zero_result);
        end

        for (int ph = 0; ph < RandomPhases; ph++) begin
            if (ph == 0) begin
                write_register(REG_CENTER_H, 20'(CENTER_H_RESET));
                write_register(REG_CENTER_V, 20'(CENTER_V_RESET));
                write_register(REG_GAIN_T, 20'(GAIN_T_RESET));
                write_register(REG_GAIN_F, 20'(GAIN_F_RESET));
                write_register(REG_LIMIT, LIMIT_RESET);
            end else begin
                write_register(REG_CENTER_H, 20'(pick_center()));
                write_register(REG_CENTER_V, 20'(pick_center()));
                write_register(REG_GAIN_T, 20'(pick_gain()));
                write_register(REG_GAIN_F, 20'(pick_gain()));
                pick = $urandom_range(0, 7);
                if (pick == 0) lim = '0;
                else if (pick == 1) lim = LIMIT_CAP;
                else if (pick == 2) lim = LimitWidth'($urandom_range(524289, 1048575));
                else lim = LimitWidth'($urandom_range(1, 524288));
                write_register(REG_LIMIT, lim);
                if ($urandom_range(0, 2) == 0)
                    write_register(CfgIdxWidth'($urandom_range(RegSpareLo, RegSpareHi)),
                                   LimitWidth'($urandom()));
            end
            for (int i = 0; i < PhaseTicks; i++) begin
                if (ph == 1 && i == 0) hold_req = 1'b1;
                col = ($urandom_range(0, 9) < 7) ? near_center(ctr_col)
                                                 : CoordWidth'($urandom_range(0, 4095));
                row = ($urandom_range(0, 9) < 7) ? near_center(ctr_row)
                                                 : CoordWidth'($urandom_range(0, 4095));
                seen = ($urandom_range(0, 99) < 92);
                pick = $urandom_range(0, 99);
                if (pick < 80) elapsed = TimeWidth'($urandom_range(1000, 100000));
                else if (pick < 90) elapsed = TimeWidth'($urandom_range(0, 999));
                else elapsed = TimeWidth'($urandom());
                send_tick(col, row, seen, elapsed, (ph == 0) ? 0 : pick_gap(), 1'b0);
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        $display("run covered %0d ticks (%0d with the object lost) across %0d register writes",
                 tick_count, lost_count, write_count);
        $display("%0d results checked, %0d field mismatches", checked_count, mismatches);
        if (mismatches == 0)
            $display("visual_servo_integrator_drive_unit: match");
        else
            $display("visual_servo_integrator_drive_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/vsid_pkg.sv
sv/vsid_alu.sv
sv/vsid_core.sv
sv/visual_servo_integrator_drive_unit.sv
bench/visual_servo_integrator_drive_unit_test.sv
